// ===== design/afde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afde_pkg
// Shared widths, constants, the glyph ramp ROM and the cell tag type.
// ----------------------------------------------------------------------------
package afde_pkg;

    localparam int MAX_CELLS   = 8192;
    localparam int RAMP_LEVELS = 70;
    localparam int ROM_DEPTH   = 70;
    localparam int ROM_LAST    = ROM_DEPTH - 1;

    localparam int CHAN_W   = 8;
    localparam int SUM_W    = 10;
    localparam int BRIGHT_W = 8;
    localparam int CELL_W   = 13;
    localparam int CFG_W    = 14;
    localparam int FRAME_W  = 16;
    localparam int GLYPH_W  = 7;
    localparam int LEVEL_W  = 7;

    // floor(s/3) == (s * 2731) >> 13 for every s up to 765
    localparam int RECIP3_SHIFT = 13;
    localparam logic [11:0] RECIP3 = 12'd2731;
    localparam int PROD3_W = SUM_W + 12;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_CELLS);
    localparam logic [CFG_W-1:0] CFG_MIN   = CFG_W'(1);

    localparam logic [GLYPH_W-1:0] GLYPH_ROM [ROM_DEPTH] = '{
        7'h20, 7'h2E, 7'h27, 7'h60, 7'h5E, 7'h22, 7'h2C, 7'h3A, 7'h3B, 7'h49,
        7'h6C, 7'h21, 7'h69, 7'h3E, 7'h3C, 7'h7E, 7'h2B, 7'h5F, 7'h2D, 7'h3F,
        7'h5D, 7'h5B, 7'h7D, 7'h7B, 7'h31, 7'h29, 7'h28, 7'h7C, 7'h5C, 7'h2F,
        7'h74, 7'h66, 7'h6A, 7'h72, 7'h78, 7'h6E, 7'h75, 7'h76, 7'h63, 7'h7A,
        7'h58, 7'h59, 7'h55, 7'h4A, 7'h43, 7'h4C, 7'h51, 7'h30, 7'h4F, 7'h5A,
        7'h6D, 7'h77, 7'h71, 7'h70, 7'h64, 7'h62, 7'h6B, 7'h68, 7'h61, 7'h6F,
        7'h2A, 7'h23, 7'h4D, 7'h57, 7'h26, 7'h38, 7'h25, 7'h42, 7'h40, 7'h24
    };

    // Position, reference flag and frame number of one accepted pixel
    typedef struct packed {
        logic [CELL_W-1:0]  pos;
        logic               key;
        logic [FRAME_W-1:0] frame;
    } t_cell_tag;

    function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] idx;
        idx = (level > LEVEL_W'(ROM_LAST)) ? LEVEL_W'(ROM_LAST) : level;
        return GLYPH_ROM[idx];
    endfunction

endpackage
`default_nettype wire

// ===== design/afde_glyph_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afde_glyph_map
// Brightness to ramp level (floor(b*69/255)) and level to ASCII glyph.
// ----------------------------------------------------------------------------
module afde_glyph_map (
    input  wire logic [afde_pkg::BRIGHT_W-1:0] i_bright,
    output logic      [afde_pkg::GLYPH_W-1:0]  o_glyph
);

    localparam int PROD_W = 15;

    logic [PROD_W-1:0]           prod;
    logic [PROD_W-1:0]           quot_arg;
    logic [afde_pkg::LEVEL_W-1:0] level;

    assign prod = PROD_W'(i_bright) * PROD_W'(afde_pkg::RAMP_LEVELS - 1);
    // exact divide by 255 for values below 65535: (x + (x >> 8) + 1) >> 8
    assign quot_arg = prod + (prod >> 8) + PROD_W'(1);
    assign level    = quot_arg[PROD_W-1:8];
    assign o_glyph  = afde_pkg::ramp_glyph(level);

endmodule
`default_nettype wire

// ===== design/afde_frame_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afde_frame_ctrl
// Frame size register, cell and frame counters, reference frame flag.
// ----------------------------------------------------------------------------
module afde_frame_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [afde_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_advance,
    output afde_pkg::t_cell_tag              o_tag
);

    logic [afde_pkg::CFG_W-1:0]   r_cfg;
    logic [afde_pkg::CELL_W-1:0]  r_cell;
    logic [afde_pkg::CELL_W-1:0]  n_cell;
    logic [afde_pkg::FRAME_W-1:0] r_frame;
    logic [afde_pkg::FRAME_W-1:0] n_frame;
    logic                         r_ref_done;
    logic                         n_ref_done;
    logic [afde_pkg::CFG_W-1:0]   cells_eff;
    logic [afde_pkg::CFG_W-1:0]   cell_next;
    logic                         wrap;

    always_comb begin
        if (r_cfg < afde_pkg::CFG_MIN) begin
            cells_eff = afde_pkg::CFG_MIN;
        end else if (r_cfg > afde_pkg::CFG_RESET) begin
            cells_eff = afde_pkg::CFG_RESET;
        end else begin
            cells_eff = r_cfg;
        end
    end

    assign cell_next = afde_pkg::CFG_W'(r_cell) + afde_pkg::CFG_W'(1);
    assign wrap      = (cell_next >= cells_eff);

    always_comb begin
        n_cell     = r_cell;
        n_frame    = r_frame;
        n_ref_done = r_ref_done;
        if (i_advance) begin
            if (wrap) begin
                n_cell     = '0;
                n_frame    = r_frame + afde_pkg::FRAME_W'(1);
                n_ref_done = 1'b1;
            end else begin
                n_cell = cell_next[afde_pkg::CELL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= afde_pkg::CFG_RESET;
            r_cell     <= '0;
            r_frame    <= '0;
            r_ref_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_cell     <= n_cell;
            r_frame    <= n_frame;
            r_ref_done <= n_ref_done;
        end
    end

    assign o_tag.pos   = r_cell;
    assign o_tag.key   = !r_ref_done;
    assign o_tag.frame = r_frame;

endmodule
`default_nettype wire

// ===== design/ascii_frame_delta_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_frame_delta_encoder
// Pixel to ASCII glyph with per-cell change detection against the last frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_chan_a, i_chan_b, i_chan_c
//  out     | output    | o_out_valid / i_out_ready | o_cell_index, o_glyph,
//          |           |                           | o_key_frame, o_frame_number
//  cfg     | input     | i_cfg_we                  | i_cfg_wdata (frame cells)
//
// One pixel per clock while the output is not stalled. A pixel is held in the
// input stage, where the glyph store is read, and its word (if any) moves on to
// the output register. The store read/write pair at one port each sets the rate.
// Synchronous active-low reset clears control state; the glyph store is not
// cleared. A stalled output holds the input stage, which then drops o_in_ready.
// ----------------------------------------------------------------------------
module ascii_frame_delta_encoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [afde_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [afde_pkg::CHAN_W-1:0]   i_chan_a,
    input  wire logic [afde_pkg::CHAN_W-1:0]   i_chan_b,
    input  wire logic [afde_pkg::CHAN_W-1:0]   i_chan_c,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [afde_pkg::CELL_W-1:0]   o_cell_index,
    output logic      [afde_pkg::GLYPH_W-1:0]  o_glyph,
    output logic                               o_key_frame,
    output logic      [afde_pkg::FRAME_W-1:0]  o_frame_number
);

    logic [afde_pkg::GLYPH_W-1:0] r_mem [afde_pkg::MAX_CELLS];

    afde_pkg::t_cell_tag          tag;
    logic                         in_acc;
    logic                         s1_go;
    logic [afde_pkg::SUM_W-1:0]   sum;
    logic [afde_pkg::PROD3_W-1:0] prod3;
    logic [afde_pkg::BRIGHT_W-1:0] bright;
    logic                         fwd_hit;

    logic                          r_s1_valid;
    afde_pkg::t_cell_tag           r_s1_tag;
    logic [afde_pkg::BRIGHT_W-1:0] r_s1_bright;
    logic [afde_pkg::GLYPH_W-1:0]  r_s1_rd;
    logic                          r_s1_fwd;
    logic [afde_pkg::GLYPH_W-1:0]  r_s1_fwd_glyph;
    logic [afde_pkg::GLYPH_W-1:0]  s1_glyph;
    logic [afde_pkg::GLYPH_W-1:0]  s1_prev;
    logic                          s1_emit;

    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [afde_pkg::CELL_W-1:0]   r_out_index;
    logic [afde_pkg::GLYPH_W-1:0]  r_out_glyph;
    logic                          r_out_key;
    logic [afde_pkg::FRAME_W-1:0]  r_out_frame;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    afde_frame_ctrl u_frame_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (in_acc),
        .o_tag       (tag)
    );

    // brightness = floor(sum / 3) by reciprocal multiply
    assign sum = afde_pkg::SUM_W'(i_chan_a) + afde_pkg::SUM_W'(i_chan_b)
               + afde_pkg::SUM_W'(i_chan_c);
    assign prod3  = afde_pkg::PROD3_W'(sum) * afde_pkg::PROD3_W'(afde_pkg::RECIP3);
    assign bright = prod3[afde_pkg::RECIP3_SHIFT +: afde_pkg::BRIGHT_W];

    // store write of the word leaving stage 1 lands after this read: bypass it
    assign fwd_hit = s1_go && (r_s1_tag.pos == tag.pos);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd <= r_mem[tag.pos];
        end
        if (s1_go) begin
            r_mem[r_s1_tag.pos] <= s1_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_tag       <= tag;
            r_s1_bright    <= bright;
            r_s1_fwd       <= fwd_hit;
            r_s1_fwd_glyph <= s1_glyph;
        end
    end

    afde_glyph_map u_glyph_map (
        .i_bright (r_s1_bright),
        .o_glyph  (s1_glyph)
    );

    assign s1_prev = r_s1_fwd ? r_s1_fwd_glyph : r_s1_rd;
    assign s1_emit = r_s1_tag.key || (s1_prev != s1_glyph);

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_go) begin
            n_out_valid = s1_emit;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_out_index <= r_s1_tag.pos;
            r_out_glyph <= s1_glyph;
            r_out_key   <= r_s1_tag.key;
            r_out_frame <= r_s1_tag.frame;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_index   = r_out_index;
    assign o_glyph        = r_out_glyph;
    assign o_key_frame    = r_out_key;
    assign o_frame_number = r_out_frame;

`ifndef SYNTH
    a_key_always_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_tag.key |-> s1_emit)
        else $error("key frame cell not emitted");

    a_key_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_frame |-> o_frame_number == '0)
        else $error("key frame word outside frame zero");

    a_glyph_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_glyph >= 7'h20) && (o_glyph <= 7'h7E))
        else $error("glyph outside printable range");

    a_bypass_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && fwd_hit |-> tag.pos == '0)
        else $error("store bypass on a cell other than zero");
`endif

endmodule
`default_nettype wire
